// ===== rtl/rc2_pkg.sv =====
`default_nettype none
package rc2_pkg;

    localparam int KEY_BYTES = 128;
    localparam int KEY_WORDS = 64;

    localparam logic [1:0] OP_KEY = 2'd0;
    localparam logic [1:0] OP_ENC = 2'd1;
    localparam logic [1:0] OP_DEC = 2'd2;

    localparam logic [3:0] ROUND_FIRST = 4'd0;
    localparam logic [3:0] ROUND_LAST  = 4'd15;
    localparam logic [3:0] MASH_A      = 4'd4;
    localparam logic [3:0] MASH_B      = 4'd10;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [63:0] block_in;
    } rc2_in_t;

    typedef struct packed {
        logic [63:0] block_out;
        logic        status;
    } rc2_out_t;

    typedef struct packed {
        logic        we;
        logic [5:0]  addr;
        logic [15:0] data;
    } rc2_ek_wr_t;

    typedef struct packed {
        logic busy;
        logic ready;
    } rc2_ks_stat_t;

    typedef enum logic [3:0] {
        KS_IDLE,
        KS_FWD_RD,
        KS_FWD_WR,
        KS_MID_RD,
        KS_MID_WR,
        KS_BWD_RD,
        KS_BWD_WR,
        KS_PK_RD0,
        KS_PK_RD1,
        KS_PK_WR
    } rc2_ks_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_FETCH,
        CS_EXEC
    } rc2_cs_state_t;

    localparam logic [7:0] PITABLE [0:255] = '{
        8'hD9,8'h78,8'hF9,8'hC4,8'h19,8'hDD,8'hB5,8'hED,8'h28,8'hE9,8'hFD,8'h79,8'h4A,8'hA0,8'hD8,8'h9D,
        8'hC6,8'h7E,8'h37,8'h83,8'h2B,8'h76,8'h53,8'h8E,8'h62,8'h4C,8'h64,8'h88,8'h44,8'h8B,8'hFB,8'hA2,
        8'h17,8'h9A,8'h59,8'hF5,8'h87,8'hB3,8'h4F,8'h13,8'h61,8'h45,8'h6D,8'h8D,8'h09,8'h81,8'h7D,8'h32,
        8'hBD,8'h8F,8'h40,8'hEB,8'h86,8'hB7,8'h7B,8'h0B,8'hF0,8'h95,8'h21,8'h22,8'h5C,8'h6B,8'h4E,8'h82,
        8'h54,8'hD6,8'h65,8'h93,8'hCE,8'h60,8'hB2,8'h1C,8'h73,8'h56,8'hC0,8'h14,8'hA7,8'h8C,8'hF1,8'hDC,
        8'h12,8'h75,8'hCA,8'h1F,8'h3B,8'hBE,8'hE4,8'hD1,8'h42,8'h3D,8'hD4,8'h30,8'hA3,8'h3C,8'hB6,8'h26,
        8'h6F,8'hBF,8'h0E,8'hDA,8'h46,8'h69,8'h07,8'h57,8'h27,8'hF2,8'h1D,8'h9B,8'hBC,8'h94,8'h43,8'h03,
        8'hF8,8'h11,8'hC7,8'hF6,8'h90,8'hEF,8'h3E,8'hE7,8'h06,8'hC3,8'hD5,8'h2F,8'hC8,8'h66,8'h1E,8'hD7,
        8'h08,8'hE8,8'hEA,8'hDE,8'h80,8'h52,8'hEE,8'hF7,8'h84,8'hAA,8'h72,8'hAC,8'h35,8'h4D,8'h6A,8'h2A,
        8'h96,8'h1A,8'hD2,8'h71,8'h5A,8'h15,8'h49,8'h74,8'h4B,8'h9F,8'hD0,8'h5E,8'h04,8'h18,8'hA4,8'hEC,
        8'hC2,8'hE0,8'h41,8'h6E,8'h0F,8'h51,8'hCB,8'hCC,8'h24,8'h91,8'hAF,8'h50,8'hA1,8'hF4,8'h70,8'h39,
        8'h99,8'h7C,8'h3A,8'h85,8'h23,8'hB8,8'hB4,8'h7A,8'hFC,8'h02,8'h36,8'h5B,8'h25,8'h55,8'h97,8'h31,
        8'h2D,8'h5D,8'hFA,8'h98,8'hE3,8'h8A,8'h92,8'hAE,8'h05,8'hDF,8'h29,8'h10,8'h67,8'h6C,8'hBA,8'hC9,
        8'hD3,8'h00,8'hE6,8'hCF,8'hE1,8'h9E,8'hA8,8'h2C,8'h63,8'h16,8'h01,8'h3F,8'h58,8'hE2,8'h89,8'hA9,
        8'h0D,8'h38,8'h34,8'h1B,8'hAB,8'h33,8'hFF,8'hB0,8'hBB,8'h48,8'h0C,8'h5F,8'hB9,8'hB1,8'hCD,8'h2E,
        8'hC5,8'hF3,8'hDB,8'h47,8'hE5,8'hA5,8'h9C,8'h77,8'h0A,8'hA6,8'h20,8'h68,8'hFE,8'h7F,8'hC1,8'hAD
    };

endpackage
`default_nettype wire

// ===== rtl/rc2_mix_unit.sv =====
`default_nettype none
module rc2_mix_unit (
    input  wire logic [3:0][15:0] x,
    input  wire logic [1:0]       k,
    input  wire logic             mash,
    input  wire logic             dec,
    input  wire logic [15:0]      kw,
    output logic      [15:0]      word
);
    import rc2_pkg::*;

    logic [15:0] xk;
    logic [15:0] x1;
    logic [15:0] x2;
    logic [15:0] x3;
    logic [15:0] f;
    logic [15:0] sum;
    logic [15:0] rot_l;
    logic [15:0] rot_r;

    always_comb
    begin
        xk  = x[k];
        x1  = x[k + 2'd1];
        x2  = x[k + 2'd2];
        x3  = x[k + 2'd3];
        f   = (x1 & ~x3) + (x2 & x3);
        sum = xk + f + kw;
        case (k)
            2'd0:
            begin
                rot_l = {sum[14:0], sum[15]};
                rot_r = {xk[0], xk[15:1]};
            end
            2'd1:
            begin
                rot_l = {sum[13:0], sum[15:14]};
                rot_r = {xk[1:0], xk[15:2]};
            end
            2'd2:
            begin
                rot_l = {sum[12:0], sum[15:13]};
                rot_r = {xk[2:0], xk[15:3]};
            end
            default:
            begin
                rot_l = {sum[10:0], sum[15:11]};
                rot_r = {xk[4:0], xk[15:5]};
            end
        endcase
        if (mash)
            word = dec ? (xk - kw) : (xk + kw);
        else
            word = dec ? (rot_r - (f + kw)) : rot_l;
    end

endmodule
`default_nettype wire

// ===== rtl/rc2_key_sched.sv =====
`default_nettype none
module rc2_key_sched (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic [7:0]          key_byte,
    input  wire logic                key_last,
    output rc2_pkg::rc2_ks_stat_t    stat,
    output rc2_pkg::rc2_ek_wr_t      ek_wr
);
    import rc2_pkg::*;

    logic [7:0] kb_mem [KEY_BYTES];
    logic [7:0] rd_reg;

    rc2_ks_state_t state_reg, state_next;
    logic [7:0] count_reg, count_next;
    logic       ready_reg, ready_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] lo_reg, lo_next;
    logic [5:0] w_reg, w_next;

    logic       kb_we;
    logic [6:0] kb_waddr;
    logic [7:0] kb_wdata;
    logic [6:0] kb_raddr;
    logic [7:0] count_inc;
    logic [7:0] mid;
    logic [7:0] tmp_addr;

    always_ff @(posedge clk)
    begin
        if (kb_we)
            kb_mem[kb_waddr] <= kb_wdata;
        rd_reg <= kb_mem[kb_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KS_IDLE;
            count_reg <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        lo_reg   <= lo_next;
        w_reg    <= w_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ready_next = ready_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        lo_next    = lo_reg;
        w_next     = w_reg;
        kb_we      = 1'b0;
        kb_waddr   = count_reg[6:0];
        kb_wdata   = key_byte;
        kb_raddr   = '0;
        ek_wr      = '0;
        tmp_addr   = '0;
        count_inc  = (count_reg < 8'(KEY_BYTES)) ? count_reg + 8'd1 : count_reg;
        mid        = 8'(KEY_BYTES) - len_reg;
        case (state_reg)
            KS_IDLE:
            begin
                if (load)
                begin
                    if (count_reg < 8'(KEY_BYTES))
                    begin
                        kb_we      = 1'b1;
                        count_next = count_inc;
                    end
                    if (key_last)
                    begin
                        len_next  = count_inc;
                        prev_next = key_byte;
                        idx_next  = count_inc;
                        if (count_inc == 8'(KEY_BYTES))
                            state_next = KS_MID_RD;
                        else
                            state_next = KS_FWD_RD;
                    end
                end
            end
            KS_FWD_RD:
            begin
                tmp_addr   = idx_reg - len_reg;
                kb_raddr   = tmp_addr[6:0];
                state_next = KS_FWD_WR;
            end
            KS_FWD_WR:
            begin
                kb_we     = 1'b1;
                kb_waddr  = idx_reg[6:0];
                kb_wdata  = PITABLE[prev_reg + rd_reg];
                prev_next = kb_wdata;
                if (idx_reg == 8'(KEY_BYTES - 1))
                    state_next = KS_MID_RD;
                else
                begin
                    idx_next   = idx_reg + 8'd1;
                    state_next = KS_FWD_RD;
                end
            end
            KS_MID_RD:
            begin
                kb_raddr   = mid[6:0];
                state_next = KS_MID_WR;
            end
            KS_MID_WR:
            begin
                kb_we     = 1'b1;
                kb_waddr  = mid[6:0];
                kb_wdata  = PITABLE[rd_reg];
                prev_next = kb_wdata;
                idx_next  = mid;
                w_next    = '0;
                if (mid == 8'd0)
                    state_next = KS_PK_RD0;
                else
                    state_next = KS_BWD_RD;
            end
            KS_BWD_RD:
            begin
                tmp_addr   = idx_reg - 8'd1 + len_reg;
                kb_raddr   = tmp_addr[6:0];
                state_next = KS_BWD_WR;
            end
            KS_BWD_WR:
            begin
                tmp_addr  = idx_reg - 8'd1;
                kb_we     = 1'b1;
                kb_waddr  = tmp_addr[6:0];
                kb_wdata  = PITABLE[prev_reg ^ rd_reg];
                prev_next = kb_wdata;
                idx_next  = tmp_addr;
                if (idx_reg == 8'd1)
                    state_next = KS_PK_RD0;
                else
                    state_next = KS_BWD_RD;
            end
            KS_PK_RD0:
            begin
                kb_raddr   = {w_reg, 1'b0};
                state_next = KS_PK_RD1;
            end
            KS_PK_RD1:
            begin
                kb_raddr   = {w_reg, 1'b1};
                lo_next    = rd_reg;
                state_next = KS_PK_WR;
            end
            KS_PK_WR:
            begin
                ek_wr.we   = 1'b1;
                ek_wr.addr = w_reg;
                ek_wr.data = {rd_reg, lo_reg};
                if (w_reg == 6'(KEY_WORDS - 1))
                begin
                    ready_next = 1'b1;
                    count_next = '0;
                    state_next = KS_IDLE;
                end
                else
                begin
                    w_next     = w_reg + 6'd1;
                    state_next = KS_PK_RD0;
                end
            end
            default:
            begin
                state_next = KS_IDLE;
            end
        endcase
    end

    assign stat.busy  = (state_reg != KS_IDLE);
    assign stat.ready = ready_reg;

endmodule
`default_nettype wire

// ===== rtl/rc2_block_cipher.sv =====
// rc2 block cipher with on-chip key schedule
//
// requests: start with the request struct, taken at a clock edge where start is
// high and busy is low. operation 0 loads one key byte (first 128 kept, the
// rest dropped); key_last on a key byte starts key expansion. operation 1
// encrypts and 2 decrypts block_in; operation 3 is ignored.
// results: one per block request, shown on result for one cycle with done high.
// status 1 with a zero block means no key has been expanded yet.
// a key byte without key_last leaves busy low, so another request can follow it
// directly. expansion of an L-byte key keeps busy high until all 64 key words are written.
// a block runs 16 rounds of 4 word steps plus 8 mash steps, each a key table
// read then one pass through the shared word unit, and done rises in the cycle
// after the last step; a no-key answer comes in the cycle after start is taken.
// busy is high throughout; the receiver cannot stall, so done is never held.
// reset clears the key count and the key-loaded flag; the key memories need
// no clearing since a block is only processed after a full expansion.
`default_nettype none
module rc2_block_cipher (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire rc2_pkg::rc2_in_t request,
    output logic                  busy,
    output logic                  done,
    output rc2_pkg::rc2_out_t     result
);
    import rc2_pkg::*;

    logic [15:0] ek_mem [KEY_WORDS];
    logic [15:0] ek_rd_reg;
    logic [5:0]  ek_raddr;

    rc2_cs_state_t    state_reg, state_next;
    logic [3:0][15:0] x_reg, x_next;
    logic [3:0]       round_reg, round_next;
    logic [1:0]       k_reg, k_next;
    logic             mash_reg, mash_next;
    logic             dec_reg, dec_next;
    logic             done_reg, done_next;
    rc2_out_t         result_reg, result_next;

    rc2_ks_stat_t ks_stat;
    rc2_ek_wr_t   ek_wr;
    logic         accept;
    logic         key_load;
    logic [15:0]  mix_word;
    logic [3:0]   round_dn;

    assign busy     = (state_reg != CS_IDLE) || ks_stat.busy;
    assign accept   = start && !busy;
    assign key_load = accept && (request.operation == OP_KEY);

    rc2_key_sched u_ks (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (key_load),
        .key_byte (request.key_byte),
        .key_last (request.key_last),
        .stat     (ks_stat),
        .ek_wr    (ek_wr)
    );

    rc2_mix_unit u_mix (
        .x    (x_reg),
        .k    (k_reg),
        .mash (mash_reg),
        .dec  (dec_reg),
        .kw   (ek_rd_reg),
        .word (mix_word)
    );

    assign ek_raddr = mash_reg ? x_reg[k_reg - 2'd1][5:0] : {round_reg, k_reg};

    always_ff @(posedge clk)
    begin
        if (ek_wr.we)
            ek_mem[ek_wr.addr] <= ek_wr.data;
        ek_rd_reg <= ek_mem[ek_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        round_reg  <= round_next;
        k_reg      <= k_next;
        mash_reg   <= mash_next;
        dec_reg    <= dec_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        round_next  = round_reg;
        k_next      = k_reg;
        mash_next   = mash_reg;
        dec_next    = dec_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        round_dn    = round_reg - 4'd1;
        case (state_reg)
            CS_IDLE:
            begin
                if (accept && (request.operation == OP_ENC || request.operation == OP_DEC))
                begin
                    if (!ks_stat.ready)
                    begin
                        done_next             = 1'b1;
                        result_next.block_out = '0;
                        result_next.status    = 1'b1;
                    end
                    else
                    begin
                        dec_next   = (request.operation == OP_DEC);
                        x_next     = request.block_in;
                        mash_next  = 1'b0;
                        round_next = dec_next ? ROUND_LAST : ROUND_FIRST;
                        k_next     = dec_next ? 2'd3 : 2'd0;
                        state_next = CS_FETCH;
                    end
                end
            end
            CS_FETCH:
            begin
                state_next = CS_EXEC;
            end
            CS_EXEC:
            begin
                x_next[k_reg] = mix_word;
                state_next    = CS_FETCH;
                if (!dec_reg)
                begin
                    if (k_reg != 2'd3)
                        k_next = k_reg + 2'd1;
                    else
                    begin
                        k_next = 2'd0;
                        if (mash_reg)
                        begin
                            mash_next  = 1'b0;
                            round_next = round_reg + 4'd1;
                        end
                        else if (round_reg == ROUND_LAST)
                            state_next = CS_IDLE;
                        else if (round_reg == MASH_A || round_reg == MASH_B)
                            mash_next = 1'b1;
                        else
                            round_next = round_reg + 4'd1;
                    end
                end
                else
                begin
                    if (k_reg != 2'd0)
                        k_next = k_reg - 2'd1;
                    else
                    begin
                        k_next = 2'd3;
                        if (mash_reg)
                            mash_next = 1'b0;
                        else if (round_reg == ROUND_FIRST)
                            state_next = CS_IDLE;
                        else
                        begin
                            round_next = round_dn;
                            mash_next  = (round_dn == MASH_A || round_dn == MASH_B);
                        end
                    end
                end
                if (state_next == CS_IDLE)
                begin
                    done_next             = 1'b1;
                    result_next.block_out = x_next;
                    result_next.status    = 1'b0;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== rtl/rc2_checker.sv =====
`default_nettype none
module rc2_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire rc2_pkg::rc2_in_t  request,
    input wire logic              busy,
    input wire logic              done,
    input wire rc2_pkg::rc2_out_t result
);
    import rc2_pkg::*;

    // a result shows up only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // key bytes never produce a result
    a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.operation == OP_KEY) |=> !done)
        else $error("result after key byte");

    // no-key answer carries a zero block
    a_nokey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.block_out == 64'd0))
        else $error("no-key result with data");

    // a block request is either answered at once or keeps the block busy
    a_block_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.operation == OP_ENC || request.operation == OP_DEC))
        |=> (busy || done))
        else $error("block request dropped");

endmodule

bind rc2_block_cipher rc2_checker u_rc2_checker (.*);
`default_nettype wire

// ===== sim/tb_rc2_block_cipher.sv =====
`default_nettype none
module tb_rc2_block_cipher;
    import rc2_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    rc2_in_t request;
    logic busy;
    logic done;
    rc2_out_t result;

    rc2_block_cipher dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .done(done),
        .result(result)
    );

    // cipher state mirrored by the testbench
    logic [7:0]  key_bytes [0:127];
    int          key_len;
    logic [15:0] key_table [0:63];
    logic        key_loaded;

    rc2_in_t  pending_requests [$];
    rc2_out_t expected_blocks [$];
    int       error_count;
    int       sender_idle_pct;
    logic     hold_sender;
    int       quiet_cycles;
    logic     busy_at_edge;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [15:0] rol16(logic [15:0] x, int n);
        return (x << n) | (x >> (16 - n));
    endfunction

    function automatic logic [15:0] ror16(logic [15:0] x, int n);
        return (x >> n) | (x << (16 - n));
    endfunction

    task automatic expand_key_table(int len);
        logic [7:0] t [0:127];
        for (int i = 0; i < 128; i++)
        begin
            t[i] = key_bytes[i];
        end
        for (int i = len; i < 128; i++)
        begin
            t[i] = PITABLE[8'(t[i - 1] + t[i - len])];
        end
        t[128 - len] = PITABLE[t[128 - len]];
        for (int i = 128 - len; i > 0; i--)
        begin
            t[i - 1] = PITABLE[t[i] ^ t[i - 1 + len]];
        end
        for (int i = 0; i < 64; i++)
        begin
            key_table[i] = {t[2 * i + 1], t[2 * i]};
        end
    endtask

    function automatic logic [63:0] model_encrypt(logic [63:0] b);
        logic [15:0] x [0:3];
        for (int i = 0; i < 4; i++)
        begin
            x[i] = b[16 * i +: 16];
        end
        for (int r = 0; r < 16; r++)
        begin
            x[0] = rol16(x[0] + (x[1] & ~x[3]) + (x[2] & x[3]) + key_table[4 * r], 1);
            x[1] = rol16(x[1] + (x[2] & ~x[0]) + (x[3] & x[0]) + key_table[4 * r + 1], 2);
            x[2] = rol16(x[2] + (x[3] & ~x[1]) + (x[0] & x[1]) + key_table[4 * r + 2], 3);
            x[3] = rol16(x[3] + (x[0] & ~x[2]) + (x[1] & x[2]) + key_table[4 * r + 3], 5);
            if (r == int'(MASH_A) || r == int'(MASH_B))
            begin
                x[0] = x[0] + key_table[x[3][5:0]];
                x[1] = x[1] + key_table[x[0][5:0]];
                x[2] = x[2] + key_table[x[1][5:0]];
                x[3] = x[3] + key_table[x[2][5:0]];
            end
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    function automatic logic [63:0] model_decrypt(logic [63:0] b);
        logic [15:0] x [0:3];
        for (int i = 0; i < 4; i++)
        begin
            x[i] = b[16 * i +: 16];
        end
        for (int r = 15; r >= 0; r--)
        begin
            if (r == int'(MASH_A) || r == int'(MASH_B))
            begin
                x[3] = x[3] - key_table[x[2][5:0]];
                x[2] = x[2] - key_table[x[1][5:0]];
                x[1] = x[1] - key_table[x[0][5:0]];
                x[0] = x[0] - key_table[x[3][5:0]];
            end
            x[3] = ror16(x[3], 5) - ((x[0] & ~x[2]) + (x[1] & x[2]) + key_table[4 * r + 3]);
            x[2] = ror16(x[2], 3) - ((x[3] & ~x[1]) + (x[0] & x[1]) + key_table[4 * r + 2]);
            x[1] = ror16(x[1], 2) - ((x[2] & ~x[0]) + (x[3] & x[0]) + key_table[4 * r + 1]);
            x[0] = ror16(x[0], 1) - ((x[1] & ~x[3]) + (x[2] & x[3]) + key_table[4 * r]);
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    task automatic predict_request(rc2_in_t req);
        rc2_out_t res;
        case (req.operation)
            OP_KEY:
            begin
                if (key_len < KEY_BYTES)
                begin
                    key_bytes[key_len] = req.key_byte;
                    key_len++;
                end
                if (req.key_last)
                begin
                    expand_key_table(key_len);
                    key_loaded = 1'b1;
                    key_len = 0;
                end
            end
            OP_ENC, OP_DEC:
            begin
                if (!key_loaded)
                begin
                    res.block_out = '0;
                    res.status = 1'b1;
                end
                else
                begin
                    res.block_out = (req.operation == OP_ENC) ? model_encrypt(req.block_in)
                                                              : model_decrypt(req.block_in);
                    res.status = 1'b0;
                end
                expected_blocks.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [63:0] rand_block();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic rc2_in_t make_request(logic [1:0] op, logic [7:0] kb, logic last,
                                             logic [63:0] blk);
        rc2_in_t r;
        r.operation = op;
        r.key_byte = kb;
        r.key_last = last;
        r.block_in = blk;
        return r;
    endfunction

    task automatic queue_key(int len, logic [7:0] fill, logic use_fill);
        for (int i = 0; i < len; i++)
        begin
            pending_requests.push_back(make_request(OP_KEY, use_fill ? fill : 8'($urandom),
                                                    i == len - 1, rand_block()));
        end
    endtask

    task automatic queue_blocks(int n);
        logic [63:0] blk;
        for (int i = 0; i < n; i++)
        begin
            blk = rand_block();
            pending_requests.push_back(make_request($urandom_range(0, 1) ? OP_ENC : OP_DEC,
                                                    8'($urandom), 1'($urandom), blk));
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_blocks.size() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy_at_edge)
            begin
                void'(pending_requests.pop_front());
            end
            if (pending_requests.size() != 0 && !hold_sender
                && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                request <= pending_requests[0];
            end
            else
            begin
                start <= 1'b0;
                request <= make_request(OP_NONE, 8'($urandom), 1'($urandom), rand_block());
            end
        end
    end

    // acceptance sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_at_edge <= 1'b1;
        end
        else
        begin
            busy_at_edge <= busy;
            if (start && !busy)
            begin
                predict_request(request);
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_rc2_block_cipher: errors");
                $finish;
            end
            if (done)
            begin
                if (expected_blocks.size() == 0)
                begin
                    report_mismatch("unexpected result", result.block_out, '0);
                end
                else
                begin
                    if (result.block_out !== expected_blocks[0].block_out)
                    begin
                        report_mismatch("block_out", result.block_out,
                                        expected_blocks[0].block_out);
                    end
                    if (result.status !== expected_blocks[0].status)
                    begin
                        report_mismatch("status", 64'(result.status),
                                        64'(expected_blocks[0].status));
                    end
                    void'(expected_blocks.pop_front());
                end
            end
        end
    end

    initial
    begin
        int len;
        rst_n = 1'b0;
        key_len = 0;
        key_loaded = 1'b0;
        error_count = 0;
        sender_idle_pct = 17;
        hold_sender = 1'b0;
        for (int i = 0; i < 128; i++)
        begin
            key_bytes[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // blocks before any key, ignored operation
        pending_requests.push_back(make_request(OP_ENC, 8'hFF, 1'b1, '1));
        pending_requests.push_back(make_request(OP_DEC, 8'h00, 1'b0, '0));
        pending_requests.push_back(make_request(OP_NONE, 8'hA5, 1'b1, '1));
        // one-byte key, extreme blocks
        queue_key(1, 8'hFF, 1'b1);
        pending_requests.push_back(make_request(OP_ENC, 8'h00, 1'b0, '0));
        pending_requests.push_back(make_request(OP_DEC, 8'h00, 1'b1, '1));
        pending_requests.push_back(make_request(OP_NONE, 8'h00, 1'b0, '0));
        // key over 128 bytes, last mark on a dropped byte
        queue_key(131, 8'h00, 1'b1);
        pending_requests.push_back(make_request(OP_ENC, 8'h00, 1'b0, 64'h0123456789ABCDEF));
        pending_requests.push_back(make_request(OP_DEC, 8'h00, 1'b0, 64'hFEDCBA9876543210));
        // exactly 128 bytes
        queue_key(128, 8'h00, 1'b0);
        queue_blocks(3);

        // random phases
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 88 : 0;
            for (int s = 0; s < 6; s++)
            begin
                case ($urandom_range(0, 9))
                    0: len = 128 + $urandom_range(0, 6);
                    1: len = $urandom_range(64, 127);
                    default: len = $urandom_range(1, 16);
                endcase
                queue_key(len, 8'h00, 1'b0);
                queue_blocks($urandom_range(20, 36));
                if ($urandom_range(0, 3) == 0)
                begin
                    pending_requests.push_back(make_request(OP_NONE, 8'($urandom), 1'b1,
                                                            rand_block()));
                end
                // partial key then blocks: old table stays in use
                if (s == 1)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        pending_requests.push_back(make_request(OP_KEY, 8'($urandom), 1'b0,
                                                                rand_block()));
                    end
                    queue_blocks(4);
                end
                wait_drained();
                if (s == 2)
                begin
                    hold_sender = 1'b1;
                    wait_drained();
                    repeat (20) @(posedge clk);
                    hold_sender = 1'b0;
                end
            end
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_rc2_block_cipher: clean");
        end
        else
        begin
            $display("tb_rc2_block_cipher: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
